// ===== hw/rtl/tlph_pkg.sv =====
// ----------------------------------------------------------------------------
// Two-level perfect hash lookup: shared package
// Types and constants used by the lookup core and its remainder unit.
// ----------------------------------------------------------------------------
package tlph_pkg;

  // Input item modes.
  localparam logic [1:0] MODE_LOOKUP    = 2'd0;
  localparam logic [1:0] MODE_WR_BUCKET = 2'd1;
  localparam logic [1:0] MODE_WR_SLOT   = 2'd2;

  // Configuration register map (index = paddr[3:2]).
  localparam int unsigned CfgAddrW = 4;
  localparam logic [1:0] REG_TOP_MULT     = 2'd0;
  localparam logic [1:0] REG_TOP_ADD      = 2'd1;
  localparam logic [1:0] REG_TOP_PRIME    = 2'd2;
  localparam logic [1:0] REG_BUCKET_COUNT = 2'd3;

  localparam logic [31:0] INVALID_WORD = 32'hFFFF_FFFF;

  // One bucket record as held in the bucket store.
  typedef struct packed {
    logic [29:0] mult;
    logic [29:0] add;
    logic [29:0] prime;
    logic [12:0] slots;
    logic [11:0] base;
  } bucket_rec_t;

  // Request into the shared remainder unit.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [29:0] divisor;
  } div_req_t;

  // Response from the shared remainder unit.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [29:0] rem;
  } div_rsp_t;

endpackage

// ===== hw/rtl/tlph_if.sv =====
// ----------------------------------------------------------------------------
// Two-level perfect hash lookup: channel interfaces
// Valid/ready channels for input items and for lookup results.
// ----------------------------------------------------------------------------
interface tlph_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] key;
  logic [11:0]        position;
  logic [12:0]        sq_size;
  logic [29:0]        coef_a;
  logic [29:0]        coef_b;
  logic [29:0]        coef_p;
  logic [11:0]        base_slot;
  logic [31:0]        slot_word;

  modport source (
    output valid, mode, key, position, sq_size, coef_a, coef_b, coef_p,
           base_slot, slot_word,
    input  ready
  );
  modport sink (
    input  valid, mode, key, position, sq_size, coef_a, coef_b, coef_p,
           base_slot, slot_word,
    output ready
  );
endinterface

interface tlph_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] found_value;

  modport source (output valid, found_value, input ready);
  modport sink (input valid, found_value, output ready);
endinterface

// ===== hw/rtl/two_level_perfect_hash_lookup_core.sv =====
// ----------------------------------------------------------------------------
// Two-level perfect hash lookup core
// Answers lookups in a two-level perfect hash whose tables software loads.
// ----------------------------------------------------------------------------
// Usage. Software first sets the first-level hash through the APB port
// (multiplier, addend, prime and bucket count), then loads bucket records
// (mode 1) and slot words (mode 2) as beats on the input channel. A mode 0
// beat is a lookup; it produces exactly one beat on the result channel that
// carries the slot word of the key, or all ones when the bucket is empty or
// a modulus is zero. Write beats and mode 3 beats produce no result.
// Sequence. A write beat is taken while the core is idle, and the core
// stays ready. A lookup runs through each hash level with one multiply
// step and two passes through the shared remainder unit (start, 32 steps,
// hand-off); the first level ends with the bucket read and check, the
// second with the slot read, and then the result register is loaded. A
// store depth that is not a power of two and that the value can reach, or
// a bucket store of one entry, adds one further pass at its level. The core
// is ready again as its result is offered.
// Reset clears the sequencer and restores the register defaults; the bucket
// and slot stores are not cleared and must be written before use.
// A stalled result holds in the output register until the sink takes it; a
// lookup that finishes meanwhile waits in its last state and no new beat is
// taken until its result has moved into the output register.
// ----------------------------------------------------------------------------
module two_level_perfect_hash_lookup_core #(
  parameter int unsigned MAX_BUCKETS = 256,
  parameter int unsigned SLOT_DEPTH  = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tlph_in_if.sink                       in_i,
  tlph_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlph_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tlph_pkg::*;

  // Store index widths.
  localparam int unsigned BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int unsigned SW = $clog2(SLOT_DEPTH);

  // The first-level index is below 512 and the slot sum below 12286. A
  // power-of-two depth folds by truncation; otherwise the remainder unit
  // makes one more pass when the value can reach the depth.
  localparam bit BK_POW2 = (MAX_BUCKETS & (MAX_BUCKETS - 1)) == 0;
  localparam bit SL_POW2 = (SLOT_DEPTH & (SLOT_DEPTH - 1)) == 0;
  localparam bit BK_FOLD = (MAX_BUCKETS < 512) && (!BK_POW2 || MAX_BUCKETS == 1);
  localparam bit SL_FOLD = (SLOT_DEPTH < 12286) && !SL_POW2;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL   = 8'b0000_0010,
    S_GO    = 8'b0000_0100,
    S_WAIT  = 8'b0000_1000,
    S_BKRD  = 8'b0001_0000,
    S_BKCHK = 8'b0010_0000,
    S_SLRD  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  // Which reduction the remainder unit is working on.
  typedef enum logic [1:0] {
    PH_PRIME = 2'd0,
    PH_MOD   = 2'd1,
    PH_FOLD  = 2'd2
  } phase_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic   level_q, level_d;
  logic   hit_q, hit_d;

  logic [29:0] top_mult_q, top_add_q, top_prime_q;
  logic [8:0]  bucket_count_q;

  logic [31:0] key_q, key_d;
  logic [31:0] prod_q, prod_d;
  logic [29:0] val_q, val_d;

  bucket_rec_t bucket_mem [MAX_BUCKETS];
  logic [31:0] slot_mem [SLOT_DEPTH];
  bucket_rec_t bk_q;
  logic [31:0] slot_rd_q;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q, out_word_d;
  logic        out_load;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        in_fire;
  logic        cfg_wr;
  logic [20:0] pos_ext;
  logic        bk_we, sl_we;
  bucket_rec_t bk_wdata;
  logic [29:0] mult_sel, add_sel, prime_sel;
  logic [31:0] mul_lo;
  logic [13:0] slot_sum;

  // --------------------------------------------------------------------------
  // Configuration port: writes land in the access phase, reads are plain.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_mult_q     <= 30'd1;
      top_add_q      <= 30'd0;
      top_prime_q    <= 30'd31;
      bucket_count_q <= 9'd1;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_TOP_MULT:     top_mult_q     <= pwdata[29:0];
        REG_TOP_ADD:      top_add_q      <= pwdata[29:0];
        REG_TOP_PRIME:    top_prime_q    <= pwdata[29:0];
        REG_BUCKET_COUNT: bucket_count_q <= pwdata[8:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TOP_MULT:     prdata = {2'b0, top_mult_q};
      REG_TOP_ADD:      prdata = {2'b0, top_add_q};
      REG_TOP_PRIME:    prdata = {2'b0, top_prime_q};
      REG_BUCKET_COUNT: prdata = {23'b0, bucket_count_q};
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input handshake and table writes. Out-of-range positions are dropped.
  // --------------------------------------------------------------------------
  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign pos_ext    = {9'b0, in_i.position};
  assign bk_we      = in_fire && (in_i.mode == MODE_WR_BUCKET) &&
                      (pos_ext < 21'(MAX_BUCKETS));
  assign sl_we      = in_fire && (in_i.mode == MODE_WR_SLOT) &&
                      (pos_ext < 21'(SLOT_DEPTH));

  assign bk_wdata.mult  = in_i.coef_a;
  assign bk_wdata.add   = in_i.coef_b;
  assign bk_wdata.prime = in_i.coef_p;
  assign bk_wdata.slots = in_i.sq_size;
  assign bk_wdata.base  = in_i.base_slot;

  // Bucket store: one write port for loads, one registered read port.
  always_ff @(posedge clk_i) begin
    if (bk_we) begin
      bucket_mem[pos_ext[BW-1:0]] <= bk_wdata;
    end
    if (state_q == S_BKRD) begin
      bk_q <= bucket_mem[val_q[BW-1:0]];
    end
  end

  // Slot store: same arrangement.
  always_ff @(posedge clk_i) begin
    if (sl_we) begin
      slot_mem[pos_ext[SW-1:0]] <= in_i.slot_word;
    end
    if (state_q == S_SLRD) begin
      slot_rd_q <= slot_mem[val_q[SW-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Datapath. The level flag picks first-level registers or the bucket record.
  // --------------------------------------------------------------------------
  assign mult_sel  = level_q ? bk_q.mult  : top_mult_q;
  assign add_sel   = level_q ? bk_q.add   : top_add_q;
  assign prime_sel = level_q ? bk_q.prime : top_prime_q;

  // Only the low 32 bits of the product matter.
  assign mul_lo = key_q * {2'b0, mult_sel};

  // Slot address before folding: base plus the second-level hash.
  assign slot_sum = {2'b0, bk_q.base} + {1'b0, div_rsp.rem[12:0]};

  always_comb begin
    div_req.start    = (state_q == S_GO);
    div_req.dividend = {2'b0, val_q};
    div_req.divisor  = prime_sel;
    unique case (phase_q)
      PH_PRIME: begin
        div_req.dividend = prod_q + {2'b0, add_sel};
        div_req.divisor  = prime_sel;
      end
      PH_MOD: begin
        div_req.divisor = level_q ? {17'b0, bk_q.slots} : {21'b0, bucket_count_q};
      end
      PH_FOLD: begin
        div_req.divisor = level_q ? 30'(SLOT_DEPTH) : 30'(MAX_BUCKETS);
      end
      default: ;
    endcase
  end

  tlph_rem_unit u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  // The finished answer moves into the output register once that register is
  // free or is being emptied in the same cycle.
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    level_d = level_q;
    hit_d   = hit_q;
    key_d   = key_q;
    prod_d  = prod_q;
    val_d   = val_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && in_i.mode == MODE_LOOKUP) begin
          key_d   = unsigned'(in_i.key);
          level_d = 1'b0;
          phase_d = PH_PRIME;
          hit_d   = 1'b0;
          if (top_prime_q == '0 || bucket_count_q == '0) begin
            state_d = S_OUT;
          end else begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_d  = mul_lo;
        state_d = S_GO;
      end
      S_GO: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          val_d = div_rsp.rem;
          unique case (phase_q)
            PH_PRIME: begin
              phase_d = PH_MOD;
              state_d = S_GO;
            end
            PH_MOD: begin
              if (level_q) begin
                val_d = {16'b0, slot_sum};
              end
              if ((level_q && SL_FOLD) || (!level_q && BK_FOLD)) begin
                phase_d = PH_FOLD;
                state_d = S_GO;
              end else begin
                state_d = level_q ? S_SLRD : S_BKRD;
              end
            end
            PH_FOLD: begin
              state_d = level_q ? S_SLRD : S_BKRD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_BKRD: begin
        state_d = S_BKCHK;
      end
      S_BKCHK: begin
        // An empty bucket or a zero prime gives the invalid marker.
        if (bk_q.slots == '0 || bk_q.prime == '0) begin
          state_d = S_OUT;
        end else begin
          level_d = 1'b1;
          phase_d = PH_PRIME;
          state_d = S_MUL;
        end
      end
      S_SLRD: begin
        hit_d   = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result register: the slot word read, or the invalid marker.
  always_comb begin
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_word_d  = hit_q ? slot_rd_q : INVALID_WORD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_PRIME;
      level_q     <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      level_q     <= level_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    prod_q     <= prod_d;
    val_q      <= val_d;
    out_word_q <= out_word_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.found_value = out_word_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A stalled result beat stays put until the sink takes it.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.found_value)))
    else $error("stalled result beat changed");

  // A lookup with a zero first-level modulus goes straight to the invalid answer.
  a_zero_mod : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_i.mode == MODE_LOOKUP &&
     (top_prime_q == '0 || bucket_count_q == '0))
    |=> (state_q == S_OUT && !hit_q))
    else $error("zero modulus lookup not answered invalid");

  // The bucket record is checked only right after it was read.
  a_bk_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BKCHK) |-> ($past(state_q) == S_BKRD))
    else $error("bucket record used before its read");

  // A valid slot result always comes straight from a slot read.
  a_hit_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hit_q) |-> ($past(state_q) == S_SLRD && state_q == S_OUT))
    else $error("hit flag set outside slot read");

  // The sequencer waits for as long as the remainder unit works.
  a_div_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == S_WAIT))
    else $error("sequencer moved on while the remainder unit was busy");

endmodule

// ===== hw/rtl/tlph_rem_unit.sv =====
// ----------------------------------------------------------------------------
// Two-level perfect hash lookup: remainder unit
// Radix-2 restoring remainder of a 32-bit dividend by a 30-bit divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tlph_rem_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tlph_pkg::div_req_t req_i,
  output tlph_pkg::div_rsp_t rsp_o
);
  import tlph_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] shf_q, shf_d;
  logic [29:0] rem_q, rem_d;
  logic [29:0] dsr_q, dsr_d;
  logic [30:0] trial;

  assign trial = {rem_q, shf_q[31]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    shf_d  = shf_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      shf_d  = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      shf_d = {shf_q[30:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = 30'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[29:0];
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shf_q <= shf_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

  // A new operation is only started on an idle unit.
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("remainder unit restarted while busy");

  // The finished remainder is below its nonzero divisor.
  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && dsr_q != '0) |-> (rem_q < dsr_q))
    else $error("remainder not below divisor");

  // After a start the step count runs down to zero while the unit stays busy.
  a_done_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> ##31 (busy_q && cnt_q == 5'd0))
    else $error("remainder unit step count wrong");

endmodule

// ===== bench/two_level_perfect_hash_lookup_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Two-level perfect hash lookup core: self-checking testbench
// Loads bucket records and slot words through the input channel, sets the
// first-level hash through the APB port, and checks every lookup result
// against a hand-typed word or a predictor of the core run alongside the stimulus.
// ----------------------------------------------------------------------------
module two_level_perfect_hash_lookup_core_tb;
  import tlph_pkg::*;

  // Store depths of the core as built here (its parameter defaults).
  localparam int unsigned BUCKETS = 256;
  localparam int unsigned SLOTS   = 4096;

  // Mode 3 is not used by the core; such beats must vanish without trace.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Long enough to cover a write or a spare beat still in flight when the
  // last result has already left.
  localparam int unsigned SETTLE_CYCLES = 200;

  // Cycles without any accepted beat or bus transfer before giving up.
  localparam int unsigned QUIET_LIMIT = 4000;

  // One input beat, field for field as on the channel.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [11:0] position;
    logic [12:0] sq_size;
    logic [29:0] coef_a;
    logic [29:0] coef_b;
    logic [29:0] coef_p;
    logic [11:0] base_slot;
    logic [31:0] slot_word;
  } beat_t;

  // A stimulus row: the beat, and for lookups whose answer is obvious the
  // slot word typed in by hand instead of asking the predictor.
  typedef struct packed {
    beat_t       beat;
    bit          typed;
    logic [31:0] want;
  } row_t;

  // One setting of the first-level hash, with the length of its phase and
  // how often both sides idle while it is in force.
  typedef struct packed {
    logic [29:0] mult;
    logic [29:0] add;
    logic [29:0] prime;
    logic [8:0]  count;
    int unsigned beats;
    int unsigned idle_pct;
  } setting_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  tlph_in_if  in_ch ();
  tlph_out_if out_ch ();

  two_level_perfect_hash_lookup_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: our own copy of the registers and of both stores. The
  // loaded flags tell the stimulus which entries it may let a lookup touch,
  // since the core leaves its stores undefined until they are written.
  // --------------------------------------------------------------------------
  bit [29:0] cfg_mult  = 30'd1;
  bit [29:0] cfg_add   = 30'd0;
  bit [29:0] cfg_prime = 30'd31;
  bit [8:0]  cfg_count = 9'd1;

  bit [29:0] rec_mult    [BUCKETS];
  bit [29:0] rec_add     [BUCKETS];
  bit [29:0] rec_prime   [BUCKETS];
  bit [12:0] rec_slots   [BUCKETS];
  bit [11:0] rec_base    [BUCKETS];
  bit        rec_loaded  [BUCKETS];
  bit [31:0] slot_mem    [SLOTS];
  bit        slot_loaded [SLOTS];

  // Slot words still owed by the core, oldest first.
  logic [31:0] awaited_words [$];
  // Keys already asked, so that later lookups revisit filled buckets.
  logic [31:0] seen_keys [$];

  int unsigned mismatch_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned phase_beats = 0;
  logic [31:0] oldest_word;

  // Ten phases would be overkill; seven settings cover the interesting
  // corners: a wide spread over all buckets, every register at its top
  // (bucket count past the store depth, so the index wraps), the reset
  // values, a zero prime, a zero bucket count and two ordinary settings.
  // The last one is drawn at random at the start of the run.
  setting_t plan_cfg [7] = '{
    '{30'h2545_F491, 30'h1B87_3593, 30'd1000000007, 9'd256, 250, 25},
    '{30'h3FFF_FFFF, 30'h3FFF_FFFF, 30'h3FFF_FFFF,  9'd511, 250, 0},
    '{30'd1,         30'd0,         30'd31,         9'd1,   150, 40},
    '{30'd0,         30'd12345,     30'd0,          9'd17,  100, 25},
    '{30'd7,         30'd3,         30'd101,        9'd0,   100, 25},
    '{30'h0ACE_1234, 30'd55,        30'd97,         9'd8,   250, 40},
    '{30'd1,         30'd0,         30'd31,         9'd1,   350, 30}
  };

  task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch in %s: got %h, want %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // ((x * a + b) mod 2^32) mod p mod m; callers keep p and m nonzero.
  function automatic logic [31:0] fold_hash(logic [31:0] x, logic [29:0] a,
                                            logic [29:0] b, logic [29:0] p,
                                            logic [12:0] m);
    logic [63:0] prod;
    logic [31:0] v;
    prod = 64'(x) * 64'(a);
    v = prod[31:0] + 32'(b);
    v = v % 32'(p);
    return v % 32'(m);
  endfunction

  // Works out which bucket record and which slot a lookup of this key will
  // read under the present tables. A zero prime or bucket count means no
  // read at all; an empty bucket or a zero bucket prime means no slot read.
  function automatic void resolve_slot(input logic [31:0] key, output bit uses_rec,
                                       output logic [7:0] bk, output bit uses_slot,
                                       output logic [11:0] addr);
    logic [31:0] h;
    uses_rec  = (cfg_prime != 0) && (cfg_count != 0);
    uses_slot = 1'b0;
    bk        = '0;
    addr      = '0;
    if (uses_rec) begin
      h  = fold_hash(key, cfg_mult, cfg_add, cfg_prime, 13'(cfg_count));
      // A bucket count beyond the store folds back onto it.
      bk = 8'(h % BUCKETS);
      if (rec_slots[bk] != 0 && rec_prime[bk] != 0) begin
        h = fold_hash(key, rec_mult[bk], rec_add[bk], rec_prime[bk], rec_slots[bk]);
        // The slot address wraps round the end of the slot store.
        addr      = 12'((32'(rec_base[bk]) + h) % SLOTS);
        uses_slot = 1'b1;
      end
    end
  endfunction

  // Brings the predictor up to date with one accepted beat and, for a
  // lookup, queues the slot word the core owes for it.
  function automatic void apply_to_tables(beat_t b);
    bit          uses_rec;
    bit          uses_slot;
    logic [7:0]  bk;
    logic [11:0] addr;
    case (b.mode)
      MODE_WR_BUCKET: begin
        // Positions past the bucket store are dropped by the core.
        if (b.position < BUCKETS) begin
          rec_slots[b.position[7:0]]  = b.sq_size;
          rec_mult[b.position[7:0]]   = b.coef_a;
          rec_add[b.position[7:0]]    = b.coef_b;
          rec_prime[b.position[7:0]]  = b.coef_p;
          rec_base[b.position[7:0]]   = b.base_slot;
          rec_loaded[b.position[7:0]] = 1'b1;
        end
      end
      MODE_WR_SLOT: begin
        if (b.position < SLOTS) begin
          slot_mem[b.position]    = b.slot_word;
          slot_loaded[b.position] = 1'b1;
        end
      end
      MODE_LOOKUP: begin
        resolve_slot(b.key, uses_rec, bk, uses_slot, addr);
        awaited_words = {awaited_words, (uses_slot ? slot_mem[addr] : INVALID_WORD)};
      end
      default: begin
      end
    endcase
  endfunction

  // Fields a mode does not use still carry random bits, so that every bit
  // of every field toggles and the core is seen to ignore them.
  function automatic beat_t garbage_beat(logic [1:0] mode);
    beat_t g;
    g.mode      = mode;
    g.key       = $urandom();
    g.position  = 12'($urandom());
    g.sq_size   = 13'($urandom());
    g.coef_a    = 30'($urandom());
    g.coef_b    = 30'($urandom());
    g.coef_p    = 30'($urandom());
    g.base_slot = 12'($urandom());
    g.slot_word = $urandom();
    return g;
  endfunction

  function automatic row_t wr_bucket(logic [11:0] pos, logic [12:0] sq, logic [29:0] a,
                                     logic [29:0] b, logic [29:0] p, logic [11:0] base);
    row_t r;
    r.beat           = garbage_beat(MODE_WR_BUCKET);
    r.beat.position  = pos;
    r.beat.sq_size   = sq;
    r.beat.coef_a    = a;
    r.beat.coef_b    = b;
    r.beat.coef_p    = p;
    r.beat.base_slot = base;
    r.typed          = 1'b0;
    r.want           = '0;
    return r;
  endfunction

  function automatic row_t wr_slot(logic [11:0] pos, logic [31:0] word);
    row_t r;
    r.beat           = garbage_beat(MODE_WR_SLOT);
    r.beat.position  = pos;
    r.beat.slot_word = word;
    r.typed          = 1'b0;
    r.want           = '0;
    return r;
  endfunction

  function automatic row_t ask(logic [31:0] key, bit typed, logic [31:0] want);
    row_t r;
    r.beat     = garbage_beat(MODE_LOOKUP);
    r.beat.key = key;
    r.typed    = typed;
    r.want     = want;
    return r;
  endfunction

  function automatic row_t spare_beat();
    row_t r;
    r.beat  = garbage_beat(MODE_SPARE);
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic logic [31:0] random_word();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return INVALID_WORD;
      default: return $urandom();
    endcase
  endfunction

  // A bucket record as software might build it: mostly small squares and
  // random moduli, now and then an empty bucket, a zero prime, a size as
  // large as the slot store or a size no square would give.
  function automatic row_t fresh_bucket(logic [11:0] pos);
    logic [12:0] sq;
    logic [29:0] p;
    logic [29:0] a;
    logic [29:0] b;
    int unsigned n;
    n = $urandom_range(16, 1);
    case ($urandom_range(9))
      0:       sq = 13'd0;
      7:       sq = 13'd4096;
      8:       sq = 13'($urandom());
      9:       sq = 13'd1;
      default: sq = 13'(n * n);
    endcase
    case ($urandom_range(9))
      0:       p = 30'd0;
      1:       p = 30'($urandom_range(100, 2));
      2:       p = 30'h3FFF_FFFF;
      3:       p = 30'd1000000007;
      default: p = 30'($urandom());
    endcase
    a = ($urandom_range(15) == 0) ? 30'h3FFF_FFFF : 30'($urandom());
    b = ($urandom_range(15) == 0) ? 30'd0 : 30'($urandom());
    return wr_bucket(pos, sq, a, b, p, 12'($urandom()));
  endfunction

  // Presents one beat and holds it until the core takes it. The predictor
  // moves on at the edge of acceptance. Afterwards the sender may fall
  // idle for a short burst.
  task automatic send_row(row_t r);
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= r.beat.mode;
    in_ch.key       <= r.beat.key;
    in_ch.position  <= r.beat.position;
    in_ch.sq_size   <= r.beat.sq_size;
    in_ch.coef_a    <= r.beat.coef_a;
    in_ch.coef_b    <= r.beat.coef_b;
    in_ch.coef_p    <= r.beat.coef_p;
    in_ch.base_slot <= r.beat.base_slot;
    in_ch.slot_word <= r.beat.slot_word;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    if (r.typed) awaited_words = {awaited_words, r.want};
    else apply_to_tables(r.beat);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk_i);
    end
  endtask

  // A well-formed lookup: the bucket record and the slot it will reach are
  // written first if they have never been, then the key is asked.
  task automatic random_lookup();
    logic [31:0] key;
    logic [31:0] corner_keys [4];
    bit          uses_rec;
    bit          uses_slot;
    logic [7:0]  bk;
    logic [11:0] addr;
    corner_keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    case ($urandom_range(9))
      0:       key = corner_keys[$urandom_range(3)];
      1, 2:    key = (seen_keys.size() != 0) ?
                     seen_keys[$urandom_range(seen_keys.size() - 1)] : $urandom();
      default: key = $urandom();
    endcase
    resolve_slot(key, uses_rec, bk, uses_slot, addr);
    if (uses_rec && !rec_loaded[bk]) begin
      send_row(fresh_bucket(12'(bk)));
      phase_beats++;
      resolve_slot(key, uses_rec, bk, uses_slot, addr);
    end
    if (uses_slot && !slot_loaded[addr]) begin
      send_row(wr_slot(addr, random_word()));
      phase_beats++;
    end
    send_row(ask(key, 1'b0, '0));
    phase_beats++;
    if (seen_keys.size() < 64) seen_keys = {seen_keys, key};
    else seen_keys[$urandom_range(63)] = key;
  endtask

  // Stops sending, lets every owed result arrive, then gives a beat that
  // yields no result time to finish inside the core.
  task automatic wait_for_quiet();
    in_ch.valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One register write followed straight away by a read of the same
  // register; the bus stays selected, and the caller releases it after the
  // last transfer of a batch. Bits above the register's width are random
  // and must be dropped by the core.
  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    logic [31:0] mask;
    mask    = (idx == REG_BUCKET_COUNT) ? 32'h0000_01FF : 32'h3FFF_FFFF;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      REG_TOP_MULT:     cfg_mult  = value[29:0];
      REG_TOP_ADD:      cfg_add   = value[29:0];
      REG_TOP_PRIME:    cfg_prime = value[29:0];
      REG_BUCKET_COUNT: cfg_count = value[8:0];
      default: begin
      end
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if ((prdata & mask) !== (value & mask))
      note_mismatch("register readback", prdata & mask, value & mask);
  endtask

  // --------------------------------------------------------------------------
  // Result side: each beat is matched against the oldest owed slot word.
  // Ready drops in random bursts while a stall rate is set, so that stalls
  // land on every stage of a lookup.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_words.size() == 0) begin
        note_mismatch("result with no lookup pending", out_ch.found_value, '0);
      end else begin
        oldest_word = awaited_words.pop_front();
        if (out_ch.found_value !== oldest_word)
          note_mismatch("found_value", out_ch.found_value, oldest_word);
      end
    end
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(7, 0);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Watchdog: a hung core shows as a long stretch with no beat accepted on
  // either channel and no bus transfer under way.
  always @(posedge clk_i) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || psel === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin
    row_t        guide [$];
    setting_t    s;
    int unsigned pick;
    logic [11:0] pos;

    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_LOOKUP;
    in_ch.key       = '0;
    in_ch.position  = '0;
    in_ch.sq_size   = '0;
    in_ch.coef_a    = '0;
    in_ch.coef_b    = '0;
    in_ch.coef_p    = '0;
    in_ch.base_slot = '0;
    in_ch.slot_word = '0;
    out_ch.ready    = 1'b0;

    plan_cfg[6].mult  = 30'($urandom());
    plan_cfg[6].add   = 30'($urandom());
    plan_cfg[6].prime = 30'($urandom_range(32'h3FFF_FFFF, 1));
    plan_cfg[6].count = 9'($urandom_range(256, 1));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run on the reset values of the registers: the prime is
    // 31 and there is one bucket, so every key lands in bucket 0. Bucket 0
    // is rebuilt between groups of lookups to reach each corner.
    guide = {guide, wr_bucket(12'd0, 13'd1, 30'd1, 30'd0, 30'd31, 12'd0)};
    guide = {guide, wr_slot(12'd0, 32'hDEAD_BEEF)};
    guide = {guide, ask(32'h0000_0000, 1'b1, 32'hDEAD_BEEF)};
    guide = {guide, ask(32'hFFFF_FFFF, 1'b1, 32'hDEAD_BEEF)};
    guide = {guide, ask(32'h7FFF_FFFF, 1'b1, 32'hDEAD_BEEF)};
    guide = {guide, ask(32'h8000_0000, 1'b1, 32'hDEAD_BEEF)};
    // A record aimed past the bucket store must not land on bucket 0.
    guide = {guide, wr_bucket(12'd256, 13'd0, 30'd0, 30'd0, 30'd0, 12'd0)};
    guide = {guide, ask(32'd1, 1'b1, 32'hDEAD_BEEF)};
    // Empty bucket, then a bucket whose prime is zero.
    guide = {guide, wr_bucket(12'd0, 13'd0, 30'd1, 30'd0, 30'd31, 12'd0)};
    guide = {guide, ask(32'd7, 1'b1, INVALID_WORD)};
    guide = {guide, wr_bucket(12'd0, 13'd4, 30'd1, 30'd0, 30'd0, 12'd0)};
    guide = {guide, ask(32'd7, 1'b1, INVALID_WORD)};
    // Base at the last slot, so the slot address wraps to the bottom.
    guide = {guide, wr_slot(12'd4095, INVALID_WORD)};
    guide = {guide, wr_slot(12'd2, 32'h0000_0000)};
    guide = {guide, wr_bucket(12'd0, 13'd4096, 30'd1, 30'd0, 30'd1000000007, 12'd4095)};
    guide = {guide, ask(32'd3, 1'b1, 32'h0000_0000)};
    guide = {guide, ask(32'd0, 1'b1, INVALID_WORD)};
    // Every coefficient and the size at their tops.
    guide = {guide, wr_bucket(12'd0, 13'd8191, 30'h3FFF_FFFF, 30'h3FFF_FFFF,
                              30'h3FFF_FFFF, 12'd4095)};
    guide = {guide, ask(32'd0, 1'b0, '0)};
    // Highest bucket index, and zero coefficients on bucket 0.
    guide = {guide, wr_bucket(12'd255, 13'd9, 30'd0, 30'd0, 30'd5, 12'd0)};
    guide = {guide, wr_bucket(12'd0, 13'd9, 30'd0, 30'd0, 30'd5, 12'd0)};
    guide = {guide, ask(32'h1234_5678, 1'b1, 32'hDEAD_BEEF)};
    // The unused mode must yield nothing and disturb nothing.
    guide = {guide, spare_beat()};
    guide = {guide, ask(32'd2, 1'b1, 32'hDEAD_BEEF)};

    sender_idle_pct = 30;
    sink_stall_pct  = 30;
    foreach (guide[k]) send_row(guide[k]);

    // Random part, one phase per setting. Registers change only once the
    // core has gone quiet.
    foreach (plan_cfg[k]) begin
      s = plan_cfg[k];
      wait_for_quiet();
      cfg_write(REG_TOP_MULT,     {2'($urandom()), s.mult});
      cfg_write(REG_TOP_ADD,      {2'($urandom()), s.add});
      cfg_write(REG_TOP_PRIME,    {2'($urandom()), s.prime});
      cfg_write(REG_BUCKET_COUNT, {23'($urandom()), s.count});
      psel    <= 1'b0;
      penable <= 1'b0;
      sender_idle_pct = s.idle_pct;
      sink_stall_pct  = s.idle_pct;
      phase_beats     = 0;
      while (phase_beats < s.beats) begin
        // The tail of the run goes flat out on both sides.
        if (k == $size(plan_cfg) - 1 && phase_beats >= s.beats / 2) begin
          sender_idle_pct = 0;
          sink_stall_pct  = 0;
        end
        pick = $urandom_range(99);
        if (pick < 15) begin
          pos = ($urandom_range(4) == 0) ? 12'($urandom_range(4095, 256))
                                         : 12'($urandom_range(255));
          send_row(fresh_bucket(pos));
          phase_beats++;
        end else if (pick < 30) begin
          send_row(wr_slot(12'($urandom()), random_word()));
          phase_beats++;
        end else if (pick < 35) begin
          send_row(spare_beat());
          phase_beats++;
        end else if (pick < 37 && sender_idle_pct != 0) begin
          // Hold off until the core owes nothing, then carry on.
          wait_for_quiet();
        end else begin
          random_lookup();
        end
      end
    end

    wait_for_quiet();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/tlph_pkg.sv
hw/rtl/tlph_if.sv
hw/rtl/tlph_rem_unit.sv
hw/rtl/two_level_perfect_hash_lookup_core.sv
bench/two_level_perfect_hash_lookup_core_tb.sv
